@@ hw/rtl/srssd_pkg.sv @@
package srssd_pkg;

  // Item kinds, as carried in the low bits of the input tuser
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_PRESS = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Frame byte counter value once all five bytes are in
  localparam logic [2:0] FRAME_DONE = 3'd5;
  localparam logic [2:0] FRAME_SUM  = 3'd4;

  // Mode indicator codes
  localparam logic [1:0] IND_NONE = 2'd0;
  localparam logic [1:0] IND_HUM  = 2'd1;
  localparam logic [1:0] IND_TEMP = 2'd2;

  // Decimal point in the segment pattern
  localparam logic [7:0] DP_BIT = 8'h80;

  // Command handed from the front to the back through the queue
  typedef struct packed {
    logic [1:0] op;
    logic       start;
    logic [7:0] value;
    logic [3:0] tens;
    logic [3:0] units;
  } cmd_t;

endpackage

@@ hw/rtl/srssd_front.sv @@
module srssd_front (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [7:0] sensor_byte
  input  logic [2:0]         s_axis_tuser,  // [1:0] operation, [2] frame_start
  input  logic               queue_full,
  output logic               push,
  output srssd_pkg::cmd_t    push_cmd
);

  // Split a byte into a tens digit (saturated at nine) and a units digit
  function automatic logic [7:0] split_byte(input logic [7:0] v);
    logic [7:0] r;
    logic [4:0] t;
    logic [3:0] tens;
    r = v;
    t = 5'd0;
    if (r >= 8'd200) begin
      r = r - 8'd200;
      t = 5'd20;
    end
    if (r >= 8'd100) begin
      r = r - 8'd100;
      t = t + 5'd10;
    end
    if (r >= 8'd80) begin
      r = r - 8'd80;
      t = t + 5'd8;
    end
    if (r >= 8'd40) begin
      r = r - 8'd40;
      t = t + 5'd4;
    end
    if (r >= 8'd20) begin
      r = r - 8'd20;
      t = t + 5'd2;
    end
    if (r >= 8'd10) begin
      r = r - 8'd10;
      t = t + 5'd1;
    end
    tens = (t > 5'd9) ? 4'd9 : t[3:0];
    return {tens, r[3:0]};
  endfunction

  logic [7:0] digits;

  // Take a transfer whenever the queue has room
  assign s_axis_tready = !queue_full;

  // Classify the item and pre-split the byte; drop the unused kind
  always_comb begin
    digits          = split_byte(s_axis_tdata);
    push_cmd.op     = s_axis_tuser[1:0];
    push_cmd.start  = s_axis_tuser[2];
    push_cmd.value  = s_axis_tdata;
    push_cmd.tens   = digits[7:4];
    push_cmd.units  = digits[3:0];
    push = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] != srssd_pkg::OP_NONE);
  end

endmodule

@@ hw/rtl/srssd_queue.sv @@
module srssd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  srssd_pkg::cmd_t    push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               cmd_valid,
  output srssd_pkg::cmd_t    cmd
);

  srssd_pkg::cmd_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/srssd_back.sv @@
module srssd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  srssd_pkg::cmd_t    cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_enable,
  output logic [7:0]         out_segments,
  output logic [1:0]         out_mode
);

  // Segment pattern of a decimal digit
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'd126;
      4'd1:    p = 8'd48;
      4'd2:    p = 8'd109;
      4'd3:    p = 8'd121;
      4'd4:    p = 8'd51;
      4'd5:    p = 8'd91;
      4'd6:    p = 8'd95;
      4'd7:    p = 8'd112;
      4'd8:    p = 8'd127;
      default: p = 8'd123;
    endcase
    return p;
  endfunction

  logic [1:0] scan_position;
  logic       show_humidity;
  logic [2:0] frame_index;
  logic [7:0] frame_sum;
  logic [7:0] byte_digits [4];
  logic [3:0] digit_values [4];
  logic [1:0] indicator;

  logic       do_tick;
  logic       do_byte;
  logic       do_press;
  logic [2:0] idx;
  logic [7:0] whole_digits;
  logic [7:0] frac_digits;
  logic       latch;
  logic [7:0] pattern;

  // Pop unless a tick finds the output register full and stalled
  assign pop = cmd_valid && ((cmd.op != srssd_pkg::OP_TICK) || !out_valid || out_ready);
  assign do_tick  = pop && (cmd.op == srssd_pkg::OP_TICK);
  assign do_byte  = pop && (cmd.op == srssd_pkg::OP_BYTE);
  assign do_press = pop && (cmd.op == srssd_pkg::OP_PRESS);

  // Frame position, pair selection, checksum latch and digit pattern
  always_comb begin
    idx          = cmd.start ? 3'd0 : frame_index;
    whole_digits = show_humidity ? byte_digits[0] : byte_digits[2];
    frac_digits  = show_humidity ? byte_digits[1] : byte_digits[3];
    latch        = do_byte && (idx == srssd_pkg::FRAME_SUM) && (frame_sum == cmd.value);
    pattern      = seg_of(digit_values[scan_position]);
    if (scan_position == 2'd1) begin
      pattern = pattern | srssd_pkg::DP_BIT;
    end
  end

  // Collect frame bytes and their digits, keep the running sum
  always_ff @(posedge clk) begin
    if (do_byte && (idx < srssd_pkg::FRAME_SUM)) begin
      byte_digits[idx[1:0]] <= {cmd.tens, cmd.units};
      frame_sum <= ((idx == 3'd0) ? 8'd0 : frame_sum) + cmd.value;
    end
  end

  // Control state: frame counter, mode, scan, digits
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= 2'd0;
      show_humidity <= 1'b0;
      frame_index   <= 3'd0;
      indicator     <= srssd_pkg::IND_NONE;
      for (int i = 0; i < 4; i++) begin
        digit_values[i] <= 4'd0;
      end
    end else begin
      if (do_press) begin
        show_humidity <= !show_humidity;
      end
      if (do_tick) begin
        scan_position <= scan_position + 2'd1;
      end
      if (do_byte) begin
        if (idx < srssd_pkg::FRAME_SUM) begin
          frame_index <= idx + 3'd1;
        end else if (idx == srssd_pkg::FRAME_SUM) begin
          frame_index <= srssd_pkg::FRAME_DONE;
        end
      end
      if (latch) begin
        indicator       <= show_humidity ? srssd_pkg::IND_HUM : srssd_pkg::IND_TEMP;
        digit_values[0] <= whole_digits[7:4];
        digit_values[1] <= whole_digits[3:0];
        digit_values[2] <= frac_digits[7:4];
        digit_values[3] <= frac_digits[3:0];
      end
    end
  end

  // Output register: load on a tick, clear once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_enable   <= 4'b0001 << scan_position;
      out_segments <= pattern;
      out_mode     <= indicator;
    end
  end

  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_enable))
    else $error("digit enable not one-hot");

  a_dp_second_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_segments[7] == (out_enable == 4'b0010)))
    else $error("decimal point on wrong digit");

  a_frame_index_range: assert property (@(posedge clk) disable iff (rst)
    frame_index <= srssd_pkg::FRAME_DONE)
    else $error("frame counter out of range");

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    (digit_values[0] <= 4'd9) && (digit_values[1] <= 4'd9) &&
    (digit_values[2] <= 4'd9) && (digit_values[3] <= 4'd9))
    else $error("digit register above nine");

endmodule

@@ hw/rtl/sensor_reading_seven_segment_display_top.sv @@
// Four-digit multiplexed seven-segment driver for a temperature/humidity
// sensor. Each input transfer is a refresh tick, a sensor frame byte or a
// button press (tuser[1:0] = 0, 1, 2; tuser[2] marks the first byte of a
// frame). A tick yields one output transfer with the one-hot digit enable,
// that digit's segments (decimal point in bit 7, shown on the second digit)
// and the mode indicator; bytes and presses yield none. A frame whose fifth
// byte equals the 8-bit sum of the first four latches the selected pair.
// One item is taken every cycle while the queue has room: a two-entry
// command queue sits between the input classifier and the executing stage,
// and only a tick meeting a full, stalled output register holds the queue,
// so throughput drops below one per cycle only while m_axis_tready is low
// and, once the queue has filled, in the cycle in which it rises again. An
// input tick passes through the command queue and then the output register
// before output valid rises.
module sensor_reading_seven_segment_display_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sensor_byte
  input  logic [2:0]  s_axis_tuser,   // [1:0] operation, [2] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [3:0] digit_enable, [11:4] segment_pattern,
                                      // [13:12] mode_indicator, [15:14] zero
);

  logic            push;
  srssd_pkg::cmd_t push_cmd;
  logic            queue_full;
  logic            pop;
  logic            cmd_valid;
  srssd_pkg::cmd_t cmd;
  logic [3:0]      out_enable;
  logic [7:0]      out_segments;
  logic [1:0]      out_mode;

  srssd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  srssd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  srssd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_enable   (out_enable),
    .out_segments (out_segments),
    .out_mode     (out_mode)
  );

  // Pack the result fields
  assign m_axis_tdata = {2'b00, out_mode, out_segments, out_enable};

endmodule

@@ test/display_scoreboard.sv @@
`timescale 1ns / 100ps

module display_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sensor_byte
  input  logic [2:0]  s_axis_tuser,   // [1:0] operation, [2] frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [3:0] digit_enable, [11:4] segment_pattern,
                                      // [13:12] mode_indicator, [15:14] zero
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [3:0] enable;
    logic [7:0] segments;
    logic [1:0] mode;
  } scan_out_t;

  // Shadow copy of the display state
  logic [1:0] scan_pos;
  logic       show_hum;
  logic [2:0] frame_pos;
  logic [7:0] frame_buf [4];
  logic [3:0] digit_val [4];
  logic [1:0] mode_now;

  // Scan outputs predicted but not yet seen on the master side
  scan_out_t  scans_due [$];

  function automatic logic [7:0] glyph_of(input logic [3:0] d);
    case (d)
      4'd0:    glyph_of = 8'd126;
      4'd1:    glyph_of = 8'd48;
      4'd2:    glyph_of = 8'd109;
      4'd3:    glyph_of = 8'd121;
      4'd4:    glyph_of = 8'd51;
      4'd5:    glyph_of = 8'd91;
      4'd6:    glyph_of = 8'd95;
      4'd7:    glyph_of = 8'd112;
      4'd8:    glyph_of = 8'd127;
      default: glyph_of = 8'd123;
    endcase
  endfunction

  // Tens of a reading, held at nine for readings of a hundred or more
  function automatic logic [3:0] tens_of_reading(input logic [7:0] v);
    logic [7:0] t;
    t = v / 8'd10;
    tens_of_reading = (t > 8'd9) ? 4'd9 : t[3:0];
  endfunction

  task automatic latch_reading(input logic [7:0] whole, input logic [7:0] frac);
    digit_val[0] = tens_of_reading(whole);
    digit_val[1] = 4'(whole % 8'd10);
    digit_val[2] = tens_of_reading(frac);
    digit_val[3] = 4'(frac % 8'd10);
  endtask

  // Collect one frame byte; the fifth byte is the checksum
  task automatic take_frame_byte(input logic [7:0] value, input logic first);
    logic [7:0] sum;
    if (first)
      frame_pos = 3'd0;
    if (frame_pos < srssd_pkg::FRAME_SUM) begin
      frame_buf[frame_pos[1:0]] = value;
      frame_pos = frame_pos + 3'd1;
    end else if (frame_pos == srssd_pkg::FRAME_SUM) begin
      sum = frame_buf[0] + frame_buf[1] + frame_buf[2] + frame_buf[3];
      if (sum == value) begin
        if (show_hum) begin
          mode_now = srssd_pkg::IND_HUM;
          latch_reading(frame_buf[0], frame_buf[1]);
        end else begin
          mode_now = srssd_pkg::IND_TEMP;
          latch_reading(frame_buf[2], frame_buf[3]);
        end
      end
      frame_pos = srssd_pkg::FRAME_DONE;
    end
  endtask

  always @(posedge clk) begin
    scan_out_t want;
    scan_out_t got;
    if (rst) begin
      scan_pos   = 2'd0;
      show_hum   = 1'b0;
      frame_pos  = 3'd0;
      mode_now   = srssd_pkg::IND_NONE;
      for (int i = 0; i < 4; i++) begin
        frame_buf[i] = 8'd0;
        digit_val[i] = 4'd0;
      end
      scans_due.delete();
      mismatches = 0;
    end else begin
      // Compare an output transfer with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tdata[13:12]};
        if (scans_due.size() == 0) begin
          $display("%0t: unexpected output transfer %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = scans_due.pop_front();
          if (got.enable !== want.enable) begin
            $display("%0t: digit enable expected %h, got %h", $time, want.enable, got.enable);
            mismatches++;
          end
          if (got.segments !== want.segments) begin
            $display("%0t: segments expected %h, got %h", $time, want.segments,
                     got.segments);
            mismatches++;
          end
          if (got.mode !== want.mode) begin
            $display("%0t: mode expected %0d, got %0d", $time, want.mode, got.mode);
            mismatches++;
          end
        end
      end
      // Advance the shadow state on an input transfer
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser[1:0])
          srssd_pkg::OP_TICK: begin
            want.enable   = 4'd1 << scan_pos;
            want.segments = glyph_of(digit_val[scan_pos]) |
                            ((scan_pos == 2'd1) ? srssd_pkg::DP_BIT : 8'd0);
            want.mode     = mode_now;
            scans_due.push_back(want);
            scan_pos = scan_pos + 2'd1;
          end
          srssd_pkg::OP_BYTE:  take_frame_byte(s_axis_tdata, s_axis_tuser[2]);
          srssd_pkg::OP_PRESS: show_hum = ~show_hum;
          default: ;
        endcase
      end
    end
    outstanding = scans_due.size();
  end

endmodule

@@ test/tb_sensor_reading_seven_segment_display_top.sv @@
`timescale 1ns / 100ps

module tb_sensor_reading_seven_segment_display_top;

  localparam int ITEM_TARGET = 950;
  localparam int CALM_AFTER  = 800;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] sensor_byte
  logic [2:0]  s_axis_tuser = 3'd0;   // [1:0] operation, [2] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [3:0] digit_enable, [11:4] segment_pattern,
                                      // [13:12] mode_indicator, [15:14] zero

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int cycles = 0;
  int send_idle_odds = 2;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  always #10 clk = ~clk;

  sensor_reading_seven_segment_display_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  display_scoreboard scoreboard (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Offer one item and hold it until the transfer, then maybe pause
  task automatic send_item(input logic [1:0] op, input logic [7:0] value, input logic first);
    logic took;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= {first, op};
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end
    items_sent++;
    if (!calm && send_idle_odds != 0 && $urandom_range(1, 8) <= send_idle_odds) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] hum_int, input logic [7:0] hum_frac,
                            input logic [7:0] tmp_int, input logic [7:0] tmp_frac,
                            input bit good);
    logic [7:0] check;
    check = hum_int + hum_frac + tmp_int + tmp_frac;
    if (!good)
      check = check + 8'($urandom_range(1, 255));
    send_item(srssd_pkg::OP_BYTE, hum_int, 1'b1);
    send_item(srssd_pkg::OP_BYTE, hum_frac, 1'b0);
    send_item(srssd_pkg::OP_BYTE, tmp_int, 1'b0);
    send_item(srssd_pkg::OP_BYTE, tmp_frac, 1'b0);
    send_item(srssd_pkg::OP_BYTE, check, 1'b0);
  endtask

  task automatic scan_all_digits;
    repeat (4) send_item(srssd_pkg::OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Readings lean towards the digit boundaries and the saturation range
  function automatic logic [7:0] pick_reading;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 7))
          0:       pick_reading = 8'd0;
          1:       pick_reading = 8'd9;
          2:       pick_reading = 8'd10;
          3:       pick_reading = 8'd99;
          4:       pick_reading = 8'd100;
          5:       pick_reading = 8'd199;
          6:       pick_reading = 8'd200;
          default: pick_reading = 8'd255;
        endcase
      end
      1:       pick_reading = 8'($urandom_range(0, 99));
      default: pick_reading = 8'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Scan the reset display, all digits zero, before any frame
    scan_all_digits();
    // Temperature frame with a saturated tens digit
    send_frame(8'd45, 8'd3, 8'd255, 8'd99, 1'b1);
    // Stray byte after a complete frame is dropped
    send_item(srssd_pkg::OP_BYTE, 8'd200, 1'b0);
    scan_all_digits();
    // Switch to humidity; an unused operation does nothing
    send_item(srssd_pkg::OP_PRESS, 8'd0, 1'b0);
    send_item(srssd_pkg::OP_NONE, 8'hff, 1'b1);
    // Restart part-way through a frame
    send_item(srssd_pkg::OP_BYTE, 8'd7, 1'b1);
    send_item(srssd_pkg::OP_BYTE, 8'd8, 1'b0);
    send_frame(8'd100, 8'd0, 8'd9, 8'd1, 1'b1);
    scan_all_digits();
    // Checksum mismatch keeps the display
    send_frame(8'd12, 8'd34, 8'd56, 8'd78, 1'b0);
    send_item(srssd_pkg::OP_TICK, 8'd0, 1'b0);

    // Random part: mostly frames and ticks, some noise
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_AFTER)
        calm = 1'b1;
      if (items_sent % 100 < 5)
        send_idle_odds = $urandom_range(0, 4);
      if (!hold_go && items_sent >= HOLD_AT) begin
        // Flood ticks while the output side holds off
        hold_go = 1'b1;
        repeat (24) send_item(srssd_pkg::OP_TICK, 8'($urandom), 1'($urandom));
      end
      pick = $urandom_range(0, 19);
      if (pick < 8)
        send_item(srssd_pkg::OP_TICK, 8'($urandom), 1'($urandom));
      else if (pick < 15)
        send_frame(pick_reading(), pick_reading(), pick_reading(), pick_reading(),
                   $urandom_range(0, 3) != 0);
      else if (pick < 17)
        send_item(srssd_pkg::OP_PRESS, 8'($urandom), 1'($urandom));
      else if (pick < 19)
        send_item(srssd_pkg::OP_BYTE, 8'($urandom), 1'($urandom));
      else
        send_item(srssd_pkg::OP_NONE, 8'($urandom), 1'($urandom));
    end
    s_axis_tvalid <= 1'b0;

    // Drain the remaining scan outputs
    while (outstanding != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Output side: random stalls and one long hold-off
  initial begin
    int stall_odds;
    stall_odds = 2;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, 16) <= stall_odds) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) == 0)
          stall_odds = $urandom_range(0, 4);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
